// ----- hw/rtl/webdefr_pkg.sv -----
package webdefr_pkg;

	localparam logic [3:0] OPCODE_TEXT  = 4'h1;
	localparam logic [3:0] OPCODE_CLOSE = 4'h8;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;

	localparam logic [1:0] MASK_LAST_POS = 2'd3;

	typedef enum logic [1:0] {
		KIND_TEXT  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_CLOSE = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		PH_OPCODE  = 5'b00001,
		PH_LEN     = 5'b00010,
		PH_EXT     = 5'b00100,
		PH_MASK    = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload;
		logic       last;
	} result_t;

	typedef struct packed {
		logic step;
		logic emit;
		logic closed;
	} parse_ctl_t;

endpackage

// ----- hw/rtl/websocket_frame_deframer.sv -----
// Client-to-server frame parser: one stream byte per transfer on the data
// channel, at most one result per byte on the result channel. A byte is
// taken every cycle while the result side keeps up; throughput is one byte
// per clock, set by the single header/unmask step between the input register
// and the result register; each result is loaded into the result register
// once it is free. Text payload bytes come out unmasked with last_byte on
// the final one; an empty text frame gives one empty marker, and a close
// frame one close marker, after which every byte is swallowed until reset.
module websocket_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic       last_byte
);
	import webdefr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	parse_ctl_t ctl;
	result_t    res;
	result_t    res_q;

	webdefr_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data_byte  (data_byte),
		.step       (ctl.step),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1)
	);

	webdefr_parser u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.out_free (out_free),
		.ctl      (ctl),
		.res      (res)
	);

	webdefr_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.res          (res),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.res_q        (res_q)
	);

	assign kind         = res_q.kind;
	assign payload_byte = res_q.payload;
	assign last_byte    = res_q.last;

	a_closed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.closed |-> !ctl.emit)
		else $error("result produced after close");

	a_close_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ctl.closed) |-> $past(ctl.step) && $past(ctl.emit))
		else $error("link closed without a close transfer");

	a_marker_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_EMPTY || kind == KIND_CLOSE)
		|-> last_byte && payload_byte == 8'h00)
		else $error("marker result with bad fields");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !(ctl.step && ctl.emit))
		else $error("pending result overwritten");

endmodule

// ----- hw/rtl/webdefr_in_stage.sv -----
module webdefr_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	input  logic       step,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import webdefr_pkg::*;

	logic load;

	assign data_ready = !valid_s1 || step;
	assign load       = data_valid && data_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

// ----- hw/rtl/webdefr_parser.sv -----
module webdefr_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s1,
	input  logic [7:0]              byte_s1,
	input  logic                    out_free,
	output webdefr_pkg::parse_ctl_t ctl,
	output webdefr_pkg::result_t    res
);
	import webdefr_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  opcode_q, opcode_n;
	logic [63:0] remain_q, remain_n;
	logic [3:0]  ext_left_q, ext_left_n;
	logic [31:0] key_q, key_n;
	logic [1:0]  mpos_q, mpos_n;
	logic        closed_q, closed_n;
	logic        emit;
	logic [6:0]  len7;
	logic [7:0]  key_byte;

	assign len7     = byte_s1[6:0];
	assign key_byte = key_q[{~mpos_q, 3'b000} +: 8];

	always_comb begin
		phase_n    = phase_q;
		opcode_n   = opcode_q;
		remain_n   = remain_q;
		ext_left_n = ext_left_q;
		key_n      = key_q;
		mpos_n     = mpos_q;
		closed_n   = closed_q;
		emit       = 1'b0;
		res        = '{kind: KIND_TEXT, payload: 8'h00, last: 1'b0};
		if (!closed_q) begin
			unique case (phase_q)
				PH_LEN: begin
					remain_n = '0;
					if (len7 == LEN_EXT16) begin
						ext_left_n = EXT16_BYTES;
						phase_n    = PH_EXT;
					end else if (len7 == LEN_EXT64) begin
						ext_left_n = EXT64_BYTES;
						phase_n    = PH_EXT;
					end else begin
						remain_n = {57'd0, len7};
						mpos_n   = '0;
						phase_n  = PH_MASK;
					end
				end
				PH_EXT: begin
					remain_n   = {remain_q[55:0], byte_s1};
					ext_left_n = ext_left_q - 4'd1;
					if (ext_left_n == 4'd0) begin
						mpos_n  = '0;
						phase_n = PH_MASK;
					end
				end
				PH_MASK: begin
					key_n = {key_q[23:0], byte_s1};
					if (mpos_q == MASK_LAST_POS) begin
						mpos_n = '0;
						if (remain_q == 64'd0) begin
							phase_n = PH_OPCODE;
							if (opcode_q == OPCODE_TEXT) begin
								emit = 1'b1;
								res  = '{kind: KIND_EMPTY, payload: 8'h00, last: 1'b1};
							end
						end else begin
							phase_n = PH_PAYLOAD;
						end
					end else begin
						mpos_n = mpos_q + 2'd1;
					end
				end
				PH_PAYLOAD: begin
					remain_n = remain_q - 64'd1;
					mpos_n   = mpos_q + 2'd1;
					if (remain_q == 64'd1) begin
						phase_n = PH_OPCODE;
						mpos_n  = '0;
					end
					if (opcode_q == OPCODE_TEXT) begin
						emit = 1'b1;
						res  = '{kind: KIND_TEXT, payload: byte_s1 ^ key_byte,
							last: (remain_q == 64'd1)};
					end
				end
				default: begin
					opcode_n = byte_s1[3:0];
					if (opcode_n == OPCODE_CLOSE) begin
						closed_n = 1'b1;
						phase_n  = PH_OPCODE;
						emit     = 1'b1;
						res      = '{kind: KIND_CLOSE, payload: 8'h00, last: 1'b1};
					end else begin
						phase_n = PH_LEN;
					end
				end
			endcase
		end
	end

	// an item with no result never waits for the output register
	assign ctl.step   = valid_s1 && (!emit || out_free);
	assign ctl.emit   = emit;
	assign ctl.closed = closed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OPCODE;
			opcode_q   <= '0;
			remain_q   <= '0;
			ext_left_q <= '0;
			key_q      <= '0;
			mpos_q     <= '0;
			closed_q   <= 1'b0;
		end else if (ctl.step) begin
			phase_q    <= phase_n;
			opcode_q   <= opcode_n;
			remain_q   <= remain_n;
			ext_left_q <= ext_left_n;
			key_q      <= key_n;
			mpos_q     <= mpos_n;
			closed_q   <= closed_n;
		end
	end

endmodule

// ----- hw/rtl/webdefr_out_stage.sv -----
module webdefr_out_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  webdefr_pkg::parse_ctl_t ctl,
	input  webdefr_pkg::result_t    res,
	output logic                    out_free,
	output logic                    result_valid,
	input  logic                    result_ready,
	output webdefr_pkg::result_t    res_q
);
	import webdefr_pkg::*;

	logic load;

	assign out_free = !result_valid || result_ready;
	assign load     = ctl.step && ctl.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule
